// ===== rtl/core/rwmf_pkg.sv =====
// Shared types and constants of the RGB window median filter.
// No dependencies; every other file of the block imports this package.
package rwmf_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int PIX_W        = 8;
  localparam int NUM_CH       = 3;
  localparam int KEY_W        = PIX_W + 1;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int RAD_FIELD_W  = 3;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int RST_LINE_WIDTH   = 1280;
  localparam int RST_FRAME_HEIGHT = 720;
  localparam int RST_RADIUS       = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  // Item kinds on the input channel
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Empty sort cell: above every pixel value
  localparam logic [KEY_W-1:0] KEY_EMPTY = 9'h100;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix3_t;  // [0] red, [1] green, [2] blue
  typedef logic [NUM_CH-1:0][KEY_W-1:0] key3_t;
  typedef logic [NUM_CH-1:0]            flag3_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } chain_ctrl_t;

endpackage

// ===== rtl/core/rwmf_chan_if.sv =====
// Handshake channels of the RGB window median filter: pixel input,
// median output and configuration write. Depends on rwmf_pkg.
interface rwmf_in_if;
  import rwmf_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  modport source (output valid, func, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, func, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rwmf_out_if;
  import rwmf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface rwmf_cfg_if;
  import rwmf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rwmf_sort_cell.sv =====
// One cell of the insertion sort chain: holds one key per color channel.
// Depends on rwmf_pkg.
module rwmf_sort_cell
  import rwmf_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  pix3_t       new_px,
  input  key3_t       left_key,
  input  flag3_t      left_gt,
  output key3_t       key,
  output flag3_t      gt
);

  key3_t key_r;
  key3_t key_nxt;
  key3_t new_key;

  // Flag cells whose key lies above the incoming value
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      new_key[c] = {1'b0, new_px[c]};
      gt[c]      = new_key[c] < key_r[c];
    end
  end

  // Shift right past the insertion point, take the new value at it
  always_comb begin
    key_nxt = key_r;
    for (int c = 0; c < NUM_CH; c++) begin
      if (ctrl.clear) begin
        key_nxt[c] = KEY_EMPTY;
      end else if (ctrl.insert && gt[c]) begin
        key_nxt[c] = left_gt[c] ? left_key[c] : new_key[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

// ===== rtl/core/rwmf_sort_chain.sv =====
// Row of sort cells that keeps the window values of all three channels in
// ascending order and picks the median rank. Depends on rwmf_pkg, rwmf_sort_cell.
module rwmf_sort_chain
  import rwmf_pkg::*;
#(
  parameter int AREA   = 225,
  parameter int RANK_W = $clog2(AREA)
) (
  input  logic              clk,
  input  chain_ctrl_t       ctrl,
  input  pix3_t             new_px,
  input  logic [RANK_W-1:0] rank,
  output pix3_t             median
);

  key3_t  keys [AREA];
  flag3_t gts  [AREA];

  for (genvar i = 0; i < AREA; i++) begin : g_cell
    key3_t  lk;
    flag3_t lg;
    if (i == 0) begin : g_head
      assign lk = {NUM_CH{KEY_EMPTY}};
      assign lg = '0;
    end else begin : g_body
      assign lk = keys[i-1];
      assign lg = gts[i-1];
    end
    rwmf_sort_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_px   (new_px),
      .left_key (lk),
      .left_gt  (lg),
      .key      (keys[i]),
      .gt       (gts[i])
    );
  end

  // Select the median cell
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      median[c] = keys[rank][c][PIX_W-1:0];
    end
  end

endmodule

// ===== rtl/core/rgb_window_median_filter.sv =====
// RGB window median filter: channels, line store, window scan control.
// Depends on rwmf_pkg, rwmf_chan_if, rwmf_sort_chain.
//
// Usage: pixels enter on in_ch in raster order (func = pixel). Each pixel is
// written to the line store; once radius rows plus radius pixels are held,
// each pixel item produces the median pixel of an earlier position on out_ch.
// After the last pixel of a frame, flush items (func = flush) drain the
// remaining outputs one per item; the result for the frame's last pixel
// carries frame_end and returns all position counters to zero.
// Configuration writes on cfg_ch (line_width, frame_height, window_radius)
// saturate into range and restart the frame; issue them only while idle.
// Scan: an item that yields a result starts the window scan over S*S pixels,
// S = 2*radius+1, which reads one line-store pixel per cycle into the
// sort chain; an item without a result starts no scan. in_ch.ready is high
// only in the idle state. The result sits in an output register; the
// next item is accepted while it waits, and a finished scan holds until the
// receiver takes the previous result. Reset (rst_n low at a clock edge)
// restores the register defaults and clears counters and output valid.
// The line store needs no clearing pass.
module rgb_window_median_filter
  import rwmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic       clk,
  input  logic       rst_n,
  rwmf_in_if.sink    in_ch,
  rwmf_out_if.source out_ch,
  rwmf_cfg_if.sink   cfg_ch
);

  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int AREA   = SIDE * SIDE;
  localparam int RANK_W = $clog2(AREA);
  localparam int SW     = $clog2(SIDE);
  localparam int PW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int LW     = PW + HEIGHT_W;
  localparam int AW     = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1);
  localparam int DEPTH  = 2 ** AW;
  localparam int XW     = PW + 2;
  localparam int YW     = HEIGHT_W + 2;
  localparam int RST_W  = (RST_LINE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_LINE_WIDTH;
  localparam int RST_R  = (RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RST_RADIUS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t state_r;

  // Configuration
  logic [PW-1:0]       w_r;
  logic [HEIGHT_W-1:0] h_r;
  logic [RW-1:0]       r_r;

  // Position tracking
  logic [PW-1:0]       in_col_r;
  logic [HEIGHT_W-1:0] in_row_r;
  logic [AW-1:0]       in_lin_r;
  logic [PW-1:0]       out_col_r;
  logic [HEIGHT_W-1:0] out_row_r;
  logic [LW-1:0]       ob_r;
  logic [LW-1:0]       ahead_r;

  // Window scan
  logic signed [YW-1:0] yy_r;
  logic signed [XW-1:0] xx_r;
  logic signed [XW-1:0] xx0_r;
  logic [LW-1:0]        base_r;
  logic [SW-1:0]        xi_r;
  logic [SW-1:0]        yi_r;
  logic                 last_r;
  logic                 rd_vld_r;

  // Output register
  logic  out_valid_r;
  pix3_t out_px_r;
  logic  out_end_r;

  // Line store
  pix3_t mem [DEPTH];
  pix3_t mem_q;

  logic [PW-1:0]        wm1;
  logic [HEIGHT_W-1:0]  hm1;
  logic [RW+PW-1:0]     rw;
  logic [RW+PW:0]       lag;
  logic [SW-1:0]        side_m1;
  logic [RANK_W-1:0]    rank;
  logic                 in_done;
  logic                 out_last;
  logic                 acc;
  logic                 is_pixel;
  logic                 wr_en;
  logic                 emit;
  logic                 rd_en;
  logic [PW-1:0]        kx;
  logic [AW-1:0]        rd_addr;
  logic signed [YW-1:0] yy_inc;
  logic signed [YW-1:0] yy0;
  logic [CFG_DATA_W:0]  cfg_x;
  logic [RAD_FIELD_W:0] cfg_rad;
  logic                 out_free;
  chain_ctrl_t          ctrl;
  pix3_t                median;
  pix3_t                in_px;

  // Derived values
  assign wm1      = w_r - PW'(1);
  assign hm1      = h_r - HEIGHT_W'(1);
  assign rw       = (RW+PW)'(r_r) * (RW+PW)'(w_r);
  assign lag      = (RW+PW+1)'(rw) + (RW+PW+1)'(r_r);
  assign side_m1  = SW'({r_r, 1'b0});
  assign rank     = RANK_W'(((RANK_W+1)'(r_r) * (RANK_W+1)'(r_r) + (RANK_W+1)'(r_r)) << 1);
  assign in_done  = (in_row_r == h_r);
  assign out_last = (out_row_r == hm1) && (out_col_r == wm1);

  // Input decode
  assign acc      = in_ch.valid && in_ch.ready;
  assign is_pixel = (in_ch.func == FUNC_PIXEL);
  assign wr_en    = acc && is_pixel && !in_done;
  assign emit     = acc && (is_pixel ? (!in_done && (ahead_r >= LW'(lag))) : in_done);
  assign in_px    = '{in_ch.pixel_blue, in_ch.pixel_green, in_ch.pixel_red};

  // Window start row, signed
  assign yy0    = YW'(out_row_r) - YW'(r_r);
  assign yy_inc = yy_r + YW'(1);

  // Clamp column and form the store address
  always_comb begin
    if (xx_r[XW-1]) begin
      kx = '0;
    end else if (xx_r > $signed({2'b00, wm1})) begin
      kx = wm1;
    end else begin
      kx = xx_r[PW-1:0];
    end
  end
  assign rd_addr = AW'(base_r + LW'(kx));
  assign rd_en   = (state_r == ST_SCAN);

  // Configuration saturation
  assign cfg_x   = {1'b0, cfg_ch.data};
  assign cfg_rad = {1'b0, cfg_ch.data[RAD_FIELD_W-1:0]};

  assign out_free = !out_valid_r || out_ch.ready;

  // Line store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_lin_r] <= in_px;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Sort chain
  assign ctrl.clear  = emit;
  assign ctrl.insert = rd_vld_r;

  rwmf_sort_chain #(
    .AREA   (AREA),
    .RANK_W (RANK_W)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .new_px (mem_q),
    .rank   (rank),
    .median (median)
  );

  // Control state, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      w_r         <= PW'(RST_W);
      h_r         <= HEIGHT_W'(RST_FRAME_HEIGHT);
      r_r         <= RW'(RST_R);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_lin_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      ob_r        <= '0;
      ahead_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
      out_px_r    <= '0;
    end else begin
      rd_vld_r <= rd_en;

      // Drop a result once taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Configuration write: saturate and restart the frame
      if (cfg_ch.valid && cfg_ch.ready && (cfg_ch.index <= REG_WINDOW_RADIUS)) begin
        unique case (cfg_ch.index)
          REG_LINE_WIDTH: begin
            if (cfg_x == '0) begin
              w_r <= PW'(1);
            end else if (cfg_x > (CFG_DATA_W+1)'(MAX_WIDTH)) begin
              w_r <= PW'(MAX_WIDTH);
            end else begin
              w_r <= PW'(cfg_x);
            end
          end
          REG_FRAME_HEIGHT: begin
            if (cfg_x == '0) begin
              h_r <= HEIGHT_W'(1);
            end else if (cfg_x > (CFG_DATA_W+1)'(HEIGHT_LIMIT)) begin
              h_r <= HEIGHT_W'(HEIGHT_LIMIT);
            end else begin
              h_r <= HEIGHT_W'(cfg_x);
            end
          end
          REG_WINDOW_RADIUS: begin
            if (cfg_rad == '0) begin
              r_r <= RW'(1);
            end else if (cfg_rad > (RAD_FIELD_W+1)'(MAX_RADIUS)) begin
              r_r <= RW'(MAX_RADIUS);
            end else begin
              r_r <= RW'(cfg_rad);
            end
          end
          default: begin
            r_r <= r_r;
          end
        endcase
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_lin_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        ob_r      <= '0;
        ahead_r   <= '0;
      end

      unique case (state_r)
        ST_IDLE: begin
          // Advance the input position on a stored pixel
          if (wr_en) begin
            in_lin_r <= in_lin_r + AW'(1);
            if (in_col_r == wm1) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + HEIGHT_W'(1);
            end else begin
              in_col_r <= in_col_r + PW'(1);
            end
            if (!emit) begin
              ahead_r <= ahead_r + LW'(1);
            end
          end
          if (emit) begin
            // Capture the window origin and start the scan
            yy_r   <= yy0;
            xx0_r  <= XW'(out_col_r) - XW'(r_r);
            xx_r   <= XW'(out_col_r) - XW'(r_r);
            base_r <= (out_row_r < HEIGHT_W'(r_r)) ? '0 : ob_r - LW'(rw);
            xi_r   <= '0;
            yi_r   <= '0;
            last_r <= out_last;
            state_r <= ST_SCAN;
            if (!is_pixel) begin
              ahead_r <= ahead_r - LW'(1);
            end
            // Advance the output position, or end the frame
            if (out_last) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_lin_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              ob_r      <= '0;
              ahead_r   <= '0;
            end else if (out_col_r == wm1) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + HEIGHT_W'(1);
              ob_r      <= ob_r + LW'(w_r);
            end else begin
              out_col_r <= out_col_r + PW'(1);
            end
          end
        end
        ST_SCAN: begin
          // Step through the window, one pixel per cycle
          if (xi_r == side_m1) begin
            xi_r <= '0;
            xx_r <= xx0_r;
            yi_r <= yi_r + SW'(1);
            yy_r <= yy_inc;
            if ((yy_inc >= YW'(1)) && (yy_inc <= $signed({2'b00, hm1}))) begin
              base_r <= base_r + LW'(w_r);
            end
            if (yi_r == side_m1) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            xi_r <= xi_r + SW'(1);
            xx_r <= xx_r + XW'(1);
          end
        end
        ST_DRAIN: begin
          // Wait for the last insertion to settle
          if (!rd_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand the median to the output register
          if (out_free) begin
            out_px_r    <= median;
            out_end_r   <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_px_r[0];
  assign out_ch.out_green = out_px_r[1];
  assign out_ch.out_blue  = out_px_r[2];
  assign out_ch.frame_end = out_end_r;

endmodule

// ===== rtl/core/rwmf_checker.sv =====
// Port-level checks of the RGB window median filter, bound to the top level.
// Depends on rwmf_pkg and rgb_window_median_filter.
module rwmf_checker
  import rwmf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_red,
  input logic [PIX_W-1:0] out_green,
  input logic [PIX_W-1:0] out_blue,
  input logic             frame_end
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Keep a stalled payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(frame_end))
    else $error("result payload changed while stalled");

  // A new result only comes out of a window scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a scan");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_window_median_filter rwmf_checker u_rwmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue),
  .frame_end (out_ch.frame_end)
);

// ===== verif/tb_rgb_window_median_filter.sv =====
// Self-checking testbench of the RGB window median filter: random and directed
// frames, bursty sender, stalling receiver, per-item median prediction.
// Depends on rwmf_pkg, rwmf_chan_if and rgb_window_median_filter.
module tb_rgb_window_median_filter;
  import rwmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RAD      = DEF_MAX_RADIUS;
  localparam int STORE_DEPTH  = 2 * MAX_RAD * DEF_MAX_WIDTH + 2 * MAX_RAD + 1;
  localparam int SCAN_SETTLE  = 300;    // cycles after the last result before a write
  localparam int IDLE_LIMIT   = 20000;  // cycles without any transaction
  localparam int LONG_HOLD    = 400;    // receiver hold-off in cycles
  localparam int PARTIAL_LEN  = 40;     // pixels sent into an oversized frame
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic             func;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } median_t;

  logic clk;
  logic rst_n;

  rwmf_in_if  in_ch();
  rwmf_out_if out_ch();
  rwmf_cfg_if cfg_ch();

  rgb_window_median_filter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the filter state
  logic [23:0]         pix_store [int];
  logic [12:0]         line_width_q, frame_height_q;
  logic [2:0]          radius_q;
  int                  in_col, in_row, out_col, out_row;

  pix_item_t           pending_pixels [$];
  median_t             expected_medians [$];
  pix_item_t           cur_item;

  int  err_count, medians_seen, frames_done, items_sent, idle_cycles;
  bit  in_taken;
  int  burst_left, gap_left;
  int  stall_left, pattern_left, pattern_mode;
  bit  long_hold_req;

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void clear_positions();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // Window median of the next output position; advance the output counters
  function automatic median_t window_median(int w, int h, int rad);
    int          hist [NUM_CH][256];
    int          n, ky, kx, cum, rank, lin;
    logic [23:0] px;
    median_t     res;
    logic [7:0]  med [NUM_CH];
    n = 0;
    foreach (hist[c, v]) hist[c][v] = 0;
    for (int dy = -rad; dy <= rad; dy++) begin
      ky = clamp_int(out_row + dy, 0, h - 1);
      for (int dx = -rad; dx <= rad; dx++) begin
        kx = clamp_int(out_col + dx, 0, w - 1);
        px = pix_store[(ky * w + kx) % STORE_DEPTH];
        hist[0][px[23:16]]++;
        hist[1][px[15:8]]++;
        hist[2][px[7:0]]++;
        n++;
      end
    end
    rank = n / 2;
    for (int c = 0; c < NUM_CH; c++) begin
      cum = 0;
      med[c] = 8'd255;
      for (int v = 0; v < 256; v++) begin
        cum += hist[c][v];
        if (cum > rank) begin
          med[c] = v[7:0];
          break;
        end
      end
    end
    lin = out_row * w + out_col;
    res.red = med[0]; res.green = med[1]; res.blue = med[2];
    res.frame_end = (lin == w * h - 1);
    if (res.frame_end) clear_positions();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  // Predict the effect of one accepted item; returns 1 when a median is due
  function automatic bit predict_item(pix_item_t it, output median_t res);
    int w, h, rad, total, lag, in_lin, out_lin;
    w = clamp_int(line_width_q, 1, DEF_MAX_WIDTH);
    h = clamp_int(frame_height_q, 1, HEIGHT_LIMIT);
    rad = clamp_int(radius_q, 1, MAX_RAD);
    total = w * h;
    lag = rad * w + rad;
    in_lin = in_row * w + in_col;
    out_lin = out_row * w + out_col;
    res = '{default: '0};
    if (it.func == FUNC_PIXEL) begin
      if (in_lin >= total) return 1'b0;
      pix_store[in_lin % STORE_DEPTH] = {it.red, it.green, it.blue};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (out_lin >= total || in_lin < out_lin + lag) return 1'b0;
    end else if (in_lin < total || out_lin >= total) begin
      return 1'b0;
    end
    res = window_median(w, h, rad);
    return 1'b1;
  endfunction

  // Sample all channels: check results, predict inputs, track writes
  always @(posedge clk) begin
    median_t got, want, pred;
    bit      any;
    any = 1'b0;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        any = 1'b1;
        got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.frame_end};
        medians_seen++;
        if (got.frame_end) frames_done++;
        if (expected_medians.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: unexpected result r=%0d g=%0d b=%0d end=%0b",
                     got.red, got.green, got.blue, got.frame_end);
        end else begin
          want = expected_medians.pop_front();
          if (got != want) begin
            err_count++;
            if (err_count <= 10)
              $display("ERROR: median mismatch exp r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                       want.red, want.green, want.blue, want.frame_end,
                       got.red, got.green, got.blue, got.frame_end);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        any = 1'b1;
        in_taken = 1'b1;
        items_sent++;
        if (predict_item('{in_ch.func, in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue},
                         pred))
          expected_medians.push_back(pred);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        any = 1'b1;
        case (cfg_ch.index)
          REG_LINE_WIDTH: begin
            line_width_q = cfg_ch.data;
            clear_positions();
          end
          REG_FRAME_HEIGHT: begin
            frame_height_q = cfg_ch.data;
            clear_positions();
          end
          REG_WINDOW_RADIUS: begin
            radius_q = cfg_ch.data[2:0];
            clear_positions();
          end
          default: ;
        endcase
      end
      // Watchdog on transaction-free cycles
      idle_cycles = any ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: timeout, no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drive input items in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FUNC_PIXEL;
      in_ch.pixel_red <= '0;
      in_ch.pixel_green <= '0;
      in_ch.pixel_blue <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        cur_item = pending_pixels.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= cur_item.func;
        in_ch.pixel_red <= cur_item.red;
        in_ch.pixel_green <= cur_item.green;
        in_ch.pixel_blue <= cur_item.blue;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern, stretches of full readiness, one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 200);
        pattern_mode = $urandom_range(0, 2);
      end else begin
        pattern_left--;
      end
      case (pattern_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic wait_drained();
    wait (pending_pixels.size() == 0 && !in_ch.valid && expected_medians.size() == 0);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending_pixels.push_back('{FUNC_PIXEL, r, g, b});
  endfunction

  function automatic void add_flush();
    pending_pixels.push_back('{FUNC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom)});
  endfunction

  // Queue one frame; mode 0 random, 1 extremes only, 2 constant; optional noise
  function automatic void add_frame(int w, int h, int rad, int mode, bit noise);
    int total, early;
    logic [7:0] v;
    total = w * h;
    early = total - rad * w - rad;
    if (early < 0) early = 0;
    for (int i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 15) == 0) add_flush();
      case (mode)
        0: add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        1: begin
          v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          add_pixel(v, ~v, ($urandom_range(0, 1) ? 8'hFF : 8'h00));
        end
        default: add_pixel(8'h5A, 8'hA5, 8'h00);
      endcase
    end
    // Pixel sent while results are still pending gets ignored
    if (noise) add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = early; i < total; i++) add_flush();
    if (noise) add_flush();
  endfunction

  task automatic configure(int w, int h, int rad);
    wait_drained();
    write_reg(REG_LINE_WIDTH, 13'(w));
    write_reg(REG_FRAME_HEIGHT, 13'(h));
    write_reg(REG_WINDOW_RADIUS, 13'(rad));
  endtask

  initial begin
    int w, h, rad;
    rst_n = 1'b0;
    err_count = 0; medians_seen = 0; frames_done = 0; items_sent = 0;
    idle_cycles = 0; burst_left = 0; gap_left = 0;
    stall_left = 0; pattern_left = 0; pattern_mode = 0; long_hold_req = 1'b0;
    in_ch.valid = 1'b0; in_ch.func = FUNC_PIXEL;
    in_ch.pixel_red = '0; in_ch.pixel_green = '0; in_ch.pixel_blue = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_LINE_WIDTH; cfg_ch.data = '0;
    line_width_q = 13'(RST_LINE_WIDTH);
    frame_height_q = 13'(RST_FRAME_HEIGHT);
    radius_q = 3'(RST_RADIUS);
    clear_positions();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: flush before any pixel, then tiny frames with extreme and constant values
    add_flush();
    configure(0, 0, 0);           // all saturate to the minimum
    add_frame(1, 1, 1, 1, 1'b0);
    configure(3, 3, 7);           // window larger than the frame
    add_frame(3, 3, 7, 1, 1'b0);
    configure(4, 2, 1);
    add_frame(4, 2, 1, 2, 1'b1);
    // Unknown index is ignored; the write in mid frame restarts it
    wait_drained();
    write_reg(REG_UNUSED, 13'h1FFF);
    add_pixel(8'hFF, 8'h00, 8'h80);
    add_pixel(8'h01, 8'hFE, 8'h7F);
    wait_drained();
    write_reg(REG_WINDOW_RADIUS, 13'h1FFF);  // radius 7
    add_frame(4, 2, 7, 0, 1'b0);
    configure(13'h1FFF, 13'h1FFF, 1);        // saturate to the maximum, no pixels
    // Start of the widest line and of the tallest column, smallest window
    configure(DEF_MAX_WIDTH, 1, 1);
    for (int i = 0; i < PARTIAL_LEN; i++)
      add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    configure(1, 13'h1FFF, 1);
    for (int i = 0; i < PARTIAL_LEN; i++)
      add_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // Random frames; one of them runs under a long receiver hold-off
    for (int f = 0; items_sent < 1650; f++) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      rad = $urandom_range(1, 7);
      configure(w, h, rad);
      add_frame(w, h, rad, ($urandom_range(0, 9) == 0) ? 1 : 0, $urandom_range(0, 3) == 0);
      if (f == 3) long_hold_req = 1'b1;
    end

    wait_drained();
    $display("Summary: %0d items sent, %0d medians checked over %0d frames,",
             items_sent, medians_seen, frames_done);
    $display("  sizes from 1x1 up to 40x10, partial 4096-wide and 4096-tall frames, radius 1 to 7");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatch count: %0d", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
